>>> src/h3126_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h3126_pkg: shared types, constants and functions of the hamming 31/26 block
// operation codes, parity masks, syndrome decode table and parity helpers
// ----------------------------------------------------------------------------
package h3126_pkg;

  localparam int WORD_W = 32;
  localparam int PAR_W  = 5;
  localparam int IDX_W  = 6;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [PAR_W-1:0]  par_t;
  typedef logic [IDX_W-1:0]  data_idx_t;

  typedef enum logic {
    FUNC_ENCODE  = 1'b0,
    FUNC_CORRECT = 1'b1
  } func_t;

  localparam word_t DATA_MASK = 32'hffff_ffc0;

  // one mask per parity bit, parity bit k uses PAR_MASKS[k]
  localparam word_t PAR_MASKS [PAR_W] = '{
    32'hdab5_5540,
    32'hb66c_ccc0,
    32'h71e3_c3c0,
    32'h0fe0_3fc0,
    32'h001f_ffc0
  };

  // marks a syndrome that names no data bit (zero or a parity bit)
  localparam data_idx_t NO_DATA = 6'h3f;

  // highest word bit; data index i lives at word bit 31 - i
  localparam logic [PAR_W-1:0] BIT_IDX_MAX = 5'd31;

  localparam data_idx_t SYN_TO_DATA [2**PAR_W] = '{
    NO_DATA, NO_DATA, NO_DATA, 6'd0,  NO_DATA, 6'd1,  6'd2,  6'd3,
    NO_DATA, 6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,  6'd10,
    NO_DATA, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25
  };

  function automatic par_t calc_parity(input word_t w);
    par_t p;
    p = '0;
    for (int k = 0; k < PAR_W; k++) begin
      p[k] = ^(w & PAR_MASKS[k]);
    end
    return p;
  endfunction

  function automatic par_t calc_syndrome(input word_t w);
    return calc_parity(w) ^ w[PAR_W-1:0];
  endfunction

endpackage

>>> src/h3126_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h3126_in_if: input channel of the hamming 31/26 block
// valid/ready channel carrying the operation select and the 32-bit word
// ----------------------------------------------------------------------------
interface h3126_in_if;
  logic             valid;
  logic             ready;
  h3126_pkg::func_t func;
  h3126_pkg::word_t word;

  modport source (output valid, output func, output word, input ready);
  modport sink   (input valid, input func, input word, output ready);
endinterface

>>> src/h3126_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h3126_out_if: result channel of the hamming 31/26 block
// valid/ready channel carrying the result word and the error flags
// ----------------------------------------------------------------------------
interface h3126_out_if;
  logic             valid;
  logic             ready;
  h3126_pkg::word_t word_out;
  logic             error_found;
  logic             parity_bit_error;

  modport source (output valid, output word_out, output error_found,
                  output parity_bit_error, input ready);
  modport sink   (input valid, input word_out, input error_found,
                  input parity_bit_error, output ready);
endinterface

>>> src/hamming31_26_encode_correct.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming31_26_encode_correct: hamming (31,26) encoder and single-error fixer
// encodes a 32-bit memory word or checks and repairs a stored codeword
// ----------------------------------------------------------------------------
// One result per input transfer. A transfer lands in an input register, the
// parity/syndrome logic and the bit repair sit between that register and the
// result register, so an item's result is held in the result register until
// the result channel takes it, and a new item is taken every cycle while the
// result side keeps draining (one item per clock sustained).
// Input ready only drops while both registers hold items and the result side
// stalls. Encode (func 0) clears bits 5..0 and writes the five parity bits
// into bits 4..0. Correct (func 1) forms the syndrome: zero passes the word
// through; a single set bit flags a parity-bit error and leaves the word
// alone; anything else flips the data bit it names. Bit 5 is cleared on
// encode and passed through untouched on correct. No state is kept beyond
// the two pipeline registers.
module hamming31_26_encode_correct (
  input  logic        clk,
  input  logic        rst_n,
  h3126_in_if.sink    in_ch,
  h3126_out_if.source out_ch
);
  import h3126_pkg::*;

  // input register stage
  logic  s1_valid_r;
  func_t s1_func_r;
  word_t s1_word_r;

  // result register stage
  logic  out_valid_r;
  word_t out_word_r;
  logic  out_err_r;
  logic  out_perr_r;

  // next values computed from the input register
  word_t word_nxt;
  logic  err_nxt;
  logic  perr_nxt;

  // decode helpers
  par_t      par;
  par_t      syn;
  data_idx_t idx;
  word_t     flip_mask;

  logic in_xfer;
  logic s1_ready;
  logic s2_ready;

  // result register can take a new item when empty or being drained
  assign s2_ready = !out_valid_r || out_ch.ready;
  // input register can take a new item when empty or moving forward
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_xfer  = in_ch.valid && s1_ready;

  assign in_ch.ready = s1_ready;

  // ecc datapath between the two registers
  always_comb begin
    par       = calc_parity(s1_word_r);
    syn       = par ^ s1_word_r[PAR_W-1:0];
    idx       = SYN_TO_DATA[syn];
    // data index i sits at word bit 31 - i
    flip_mask = {{(WORD_W-1){1'b0}}, 1'b1} << (BIT_IDX_MAX - idx[PAR_W-1:0]);
    word_nxt  = s1_word_r;
    err_nxt   = 1'b0;
    perr_nxt  = 1'b0;
    unique case (s1_func_r)
      FUNC_ENCODE: begin
        // clear unused bit and parity field, then insert fresh parity
        word_nxt = (s1_word_r & DATA_MASK) | {{(WORD_W-PAR_W){1'b0}}, par};
      end
      FUNC_CORRECT: begin
        if (syn != '0) begin
          err_nxt = 1'b1;
          if (idx == NO_DATA) begin
            // syndrome names a parity bit, data is fine
            perr_nxt = 1'b1;
          end else begin
            word_nxt = s1_word_r ^ flip_mask;
          end
        end
      end
      default: begin
        word_nxt = s1_word_r;
      end
    endcase
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r <= in_ch.func;
      s1_word_r <= in_ch.word;
    end
    if (s1_valid_r && s2_ready) begin
      out_word_r <= word_nxt;
      out_err_r  <= err_nxt;
      out_perr_r <= perr_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.word_out         = out_word_r;
  assign out_ch.error_found      = out_err_r;
  assign out_ch.parity_bit_error = out_perr_r;

endmodule

>>> src/h3126_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h3126_check: port-level checker for the hamming 31/26 block
// tracks items in flight and checks latency, flags and output codewords
// ----------------------------------------------------------------------------
module h3126_check (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input h3126_pkg::word_t word_out,
  input logic             error_found,
  input logic             parity_bit_error
);
  import h3126_pkg::*;

  logic [1:0] inflight_r;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  // a result is never shown without an item in flight
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 2'd0)
    else $error("result shown with no item in flight");

  // an item entering an empty block shows up after both registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && inflight_r == 2'd0) |-> ##2 out_valid)
    else $error("result missing two cycles after transfer into empty block");

  // a parity-bit error is always also an error
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && parity_bit_error) |-> error_found)
    else $error("parity bit error without error found");

  // encoded and repaired words carry a clean syndrome
  a_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !parity_bit_error) |-> calc_syndrome(word_out) == '0)
    else $error("output codeword has nonzero syndrome");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(word_out))
    else $error("stalled result changed");

endmodule

bind hamming31_26_encode_correct h3126_check u_h3126_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .word_out         (out_ch.word_out),
  .error_found      (out_ch.error_found),
  .parity_bit_error (out_ch.parity_bit_error)
);

>>> bench/tb_hamming31_26_encode_correct.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hamming31_26_encode_correct: self-checking bench for the hamming 31/26 block
// drives encode and correct words with random gaps and result-side stalls,
// predicts every result from its own parity/syndrome model and compares each
// result transfer field by field in arrival order
// ----------------------------------------------------------------------------
module tb_hamming31_26_encode_correct;
  import h3126_pkg::*;

  // generous bound: ~720 items, each with a long send gap, a long result
  // stall and the two-stage pipeline, taken several times over
  localparam int unsigned LIMIT_CYCLES   = 200_000;
  localparam int unsigned RANDOM_ITEMS   = 700;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned SETTLE_CYCLES  = 10;

  // data bits 31..6; bit 5 unused; parity in bits 4..0
  localparam word_t CODE_DATA_BITS = 32'hffff_ffc0;
  // parity bit k covers the data bits under CHECK_MASKS[k]
  localparam logic [4:0][31:0] CHECK_MASKS = {
    32'h001f_ffc0, 32'h0fe0_3fc0, 32'h71e3_c3c0, 32'hb66c_ccc0, 32'hdab5_5540
  };

  typedef struct packed {
    word_t word_out;
    logic  error_found;
    logic  parity_bit_error;
  } ecc_result_t;

  logic clk;
  logic rst_n;

  h3126_in_if  in_ch ();
  h3126_out_if out_ch ();

  hamming31_26_encode_correct u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // results predicted at input transfer time, oldest first
  ecc_result_t predicted_results [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  // set during stretches where neither side idles
  bit          no_idle;

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------
  function automatic logic [4:0] parity_of(input word_t w);
    logic [4:0] p;
    for (int k = 0; k < 5; k++) begin
      p[k] = ^(w & CHECK_MASKS[k]);
    end
    return p;
  endfunction

  function automatic ecc_result_t hamming_predict(input func_t f, input word_t w);
    ecc_result_t r;
    logic [4:0]  syn;
    int unsigned below;
    int unsigned data_idx;
    r.word_out         = w;
    r.error_found      = 1'b0;
    r.parity_bit_error = 1'b0;
    if (f == FUNC_ENCODE) begin
      r.word_out = (w & CODE_DATA_BITS) | word_t'(parity_of(w));
    end else begin
      syn = parity_of(w) ^ w[4:0];
      if (syn != 5'd0) begin
        r.error_found = 1'b1;
        if ($countones(syn) == 1) begin
          // syndrome names a parity bit, word left alone
          r.parity_bit_error = 1'b1;
        end else begin
          // data positions skip the power-of-two slots held by parity
          below = 0;
          for (int k = 0; k < 5; k++) begin
            if (syn >= (5'd1 << k)) below++;
          end
          data_idx = int'(syn) - below - 1;
          r.word_out[31 - data_idx] = ~w[31 - data_idx];
        end
      end
    end
    return r;
  endfunction

  function automatic word_t encoded(input word_t w);
    ecc_result_t r;
    r = hamming_predict(FUNC_ENCODE, w);
    return r.word_out;
  endfunction

  // mostly short gaps, a few long ones, none during a quiet stretch
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ------------------------------------------------------------------------
  // clock, reset, initial drive
  // ------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.func   <= FUNC_ENCODE;
    in_ch.word   <= '0;
    out_ch.ready <= 1'b0;
  end

  // ------------------------------------------------------------------------
  // result side: random stalls on ready
  // ------------------------------------------------------------------------
  initial begin : result_stall
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat (1 + pick_gap()) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // ------------------------------------------------------------------------
  // result checker: every result transfer against the oldest prediction
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    ecc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("[%0t] unexpected result transfer: word_out=%h err=%b perr=%b", $realtime,
                   out_ch.word_out, out_ch.error_found, out_ch.parity_bit_error);
        end
      end else begin
        want = predicted_results.pop_front();
        if (out_ch.word_out !== want.word_out || out_ch.error_found !== want.error_found ||
            out_ch.parity_bit_error !== want.parity_bit_error) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: exp word_out=%h err=%b perr=%b, got word_out=%h err=%b perr=%b",
                     $realtime, want.word_out, want.error_found, want.parity_bit_error,
                     out_ch.word_out, out_ch.error_found, out_ch.parity_bit_error);
          end
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("hamming31_26_encode_correct verification failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------
  // one input transfer; valid stays high afterward so back-to-back items
  // never drop it within a time step
  task automatic send_word(input func_t f, input word_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.word  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted_results.push_back(hamming_predict(f, w));
  endtask

  // sender holds off until the pipeline has handed back every result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  // encode extremes: all zero, all one, alternating, only the low six bits
  task automatic test_encode_extremes();
    send_word(FUNC_ENCODE, 32'h0000_0000);
    send_word(FUNC_ENCODE, 32'hffff_ffff);
    send_word(FUNC_ENCODE, 32'haaaa_aaaa);
    send_word(FUNC_ENCODE, 32'h5555_5555);
    send_word(FUNC_ENCODE, 32'h0000_003f);
  endtask

  // correct: clean word, unused bit five, each parity bit, data bits at the
  // ends and middle, a double error and the all-zero/all-one words
  task automatic test_correct_cases();
    word_t cw;
    cw = encoded(32'h1234_5678);
    send_word(FUNC_CORRECT, cw);
    send_word(FUNC_CORRECT, cw ^ 32'h0000_0020);
    for (int k = 0; k < 5; k++) begin
      send_word(FUNC_CORRECT, cw ^ (32'h1 << k));
    end
    send_word(FUNC_CORRECT, cw ^ 32'h8000_0000);
    send_word(FUNC_CORRECT, cw ^ 32'h0000_0040);
    send_word(FUNC_CORRECT, cw ^ 32'h0004_0000);
    send_word(FUNC_CORRECT, cw ^ 32'hc000_0000);
    send_word(FUNC_CORRECT, 32'hffff_ffff);
    send_word(FUNC_CORRECT, 32'h0000_0000);
  endtask

  // mostly encode-then-corrupt codewords with zero, one or two flipped
  // bits, plus raw words for both operations
  task automatic test_random_traffic();
    int unsigned kind;
    int unsigned flips;
    word_t       w;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      // every third block of 100 items runs with no idling on either side
      no_idle = ((i / 100) % 3) == 1;
      // sender pauses now and then until the pipeline is empty
      if (i != 0 && i % 175 == 0) wait_drained();
      kind = $urandom_range(0, 9);
      w    = $urandom;
      if (kind < 2) begin
        send_word(FUNC_ENCODE, w);
      end else if (kind < 8) begin
        w     = encoded(w);
        flips = $urandom_range(0, 9);
        flips = (flips < 2) ? 0 : (flips < 8) ? 1 : 2;
        for (int unsigned j = 0; j < flips; j++) begin
          w[$urandom_range(0, 31)] ^= 1'b1;
        end
        send_word(FUNC_CORRECT, w);
      end else begin
        send_word(FUNC_CORRECT, w);
      end
    end
    no_idle = 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    no_idle        = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_encode_extremes();
    test_correct_cases();
    test_random_traffic();

    // let everything in flight come back, then idle to catch strays
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("hamming31_26_encode_correct verification clean");
    end else begin
      $display("hamming31_26_encode_correct verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/h3126_pkg.sv
src/h3126_in_if.sv
src/h3126_out_if.sv
src/hamming31_26_encode_correct.sv
src/h3126_check.sv
bench/tb_hamming31_26_encode_correct.sv
